// ===== design/blkfp_pkg.sv =====
package blkfp_pkg;

    localparam int BLOCK_BYTES     = 4096;
    localparam int CHUNK_BYTES     = 512;
    localparam int CHUNKS_IN_BLOCK = 8;
    localparam int MAX_BLOCKS      = 1024;

    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);

    localparam int POS_W    = 23;
    localparam int TE_W     = 11;
    localparam int ADDR_W   = 10;
    localparam int HASH_W   = 32;
    localparam int FIRST_W  = 13;
    localparam int CNT_W    = 4;
    localparam int MARK_W   = 14;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // block number and chunk math widths
    localparam int BLK_W    = POS_W - BLOCK_SHIFT;
    localparam int FULLC_W  = BLK_W + BLOCK_SHIFT - CHUNK_SHIFT;
    localparam int BLOCKS_W = BLK_W + 1;
    localparam int CHUNKS_W = POS_W - CHUNK_SHIFT + 1;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_SIZE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 8'd1;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_BLOCK
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] entry_index;
        logic [HASH_W-1:0] entry_value;
        logic [7:0]        card_byte;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  block_index;
        logic [HASH_W-1:0]  block_hash;
        logic               changed;
        logic [FIRST_W-1:0] first_chunk;
        logic [CNT_W-1:0]   chunk_count;
        logic [MARK_W-1:0]  marked_total;
        logic               final_res;
        logic               status;
        logic [HASH_W-1:0]  stored_value;
    } out_item_t;

    // one command from the front to the back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [HASH_W-1:0]  data;
        logic [FIRST_W-1:0] first_chunk;
        logic [CNT_W-1:0]   cnt;
        logic               last;
        logic               too_big;
    } cmd_t;

endpackage

// ===== design/blkfp_front.sv =====
module blkfp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  blkfp_pkg::in_item_t                 s_item,
    input  logic                                cfg_valid,
    input  logic [blkfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blkfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                push_valid,
    output blkfp_pkg::cmd_t                     push_cmd,
    input  logic                                q_full
);
    import blkfp_pkg::*;

    logic [POS_W-1:0]    card_size_reg, card_size_next;
    logic [TE_W-1:0]     te_reg, te_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic [POS_W-1:0]    size_eff;
    logic [POS_W-1:0]    pos_inc;
    logic [HASH_W-1:0]   hash_mul;
    logic [BLK_W-1:0]    blk;
    logic [FULLC_W-1:0]  first;
    logic [BLOCKS_W-1:0] blocks;
    logic [CHUNKS_W-1:0] chunks;
    logic [CHUNKS_W-1:0] span;
    logic [TE_W-1:0]     eff;
    logic                is_last;
    logic                blk_end;
    logic                too_big;
    logic [CNT_W-1:0]    cnt;
    logic                accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign size_eff = (card_size_reg == '0) ? POS_W'(1) : card_size_reg;
    assign pos_inc  = pos_reg + POS_W'(1);
    assign is_last  = pos_inc >= size_eff;
    assign blk_end  = is_last || (pos_inc[BLOCK_SHIFT-1:0] == '0);

    assign hash_mul = (hash_reg ^ {24'b0, s_item.card_byte}) * FNV_PRIME;

    // block number of the byte being taken
    assign blk    = pos_reg[POS_W-1:BLOCK_SHIFT];
    assign first  = {blk, {(BLOCK_SHIFT-CHUNK_SHIFT){1'b0}}};
    assign blocks = BLOCKS_W'(size_eff[POS_W-1:BLOCK_SHIFT])
                  + BLOCKS_W'(|size_eff[BLOCK_SHIFT-1:0]);
    assign chunks = CHUNKS_W'(size_eff[POS_W-1:CHUNK_SHIFT])
                  + CHUNKS_W'(|size_eff[CHUNK_SHIFT-1:0]);
    assign eff    = (te_reg > TE_W'(MAX_BLOCKS)) ? TE_W'(MAX_BLOCKS) : te_reg;
    assign too_big = (blocks > BLOCKS_W'(eff)) || (BLOCKS_W'(blk) >= BLOCKS_W'(eff));
    assign span   = chunks - CHUNKS_W'(first);

    always_comb begin
        cnt = '0;
        if (CHUNKS_W'(first) < chunks) begin
            if (span > CHUNKS_W'(CHUNKS_IN_BLOCK)) begin
                cnt = CNT_W'(CHUNKS_IN_BLOCK);
            end else begin
                cnt = CNT_W'(span);
            end
        end
    end

    always_comb begin
        push_valid           = 1'b0;
        push_cmd.kind        = CMD_BLOCK;
        push_cmd.addr        = s_item.entry_index;
        push_cmd.data        = s_item.entry_value;
        push_cmd.first_chunk = first[FIRST_W-1:0];
        push_cmd.cnt         = cnt;
        push_cmd.last        = is_last;
        push_cmd.too_big     = too_big;
        case (s_item.op)
            OP_WRITE: begin
                push_valid    = accept;
                push_cmd.kind = CMD_WRITE;
            end
            OP_READ: begin
                push_valid    = accept;
                push_cmd.kind = CMD_READ;
            end
            OP_BYTE: begin
                push_valid    = accept && blk_end;
                push_cmd.addr = blk[ADDR_W-1:0];
                push_cmd.data = hash_mul;
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        hash_next      = hash_reg;
        pos_next       = pos_reg;
        card_size_next = card_size_reg;
        te_next        = te_reg;
        if (accept && s_item.op == OP_BYTE) begin
            if (blk_end) begin
                hash_next = FNV_BASIS;
                pos_next  = is_last ? '0 : pos_inc;
            end else begin
                hash_next = hash_mul;
                pos_next  = pos_inc;
            end
        end
        if (cfg_valid) begin
            if (cfg_index == CFG_CARD_SIZE) begin
                card_size_next = cfg_data[POS_W-1:0];
            end else if (cfg_index == CFG_TABLE_ENTRIES) begin
                te_next = cfg_data[TE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= FNV_BASIS;
            pos_reg       <= '0;
            card_size_reg <= POS_W'(1);
            te_reg        <= TE_W'(MAX_BLOCKS);
        end else begin
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            card_size_reg <= card_size_next;
            te_reg        <= te_next;
        end
    end

endmodule

// ===== design/blkfp_queue.sv =====
module blkfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  blkfp_pkg::cmd_t  push_cmd,
    output logic             full,
    output logic             pop_avail,
    input  logic             pop,
    output blkfp_pkg::cmd_t  pop_cmd
);
    import blkfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    cmd_t              entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_QW'(DEPTH));
    assign pop_avail = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_avail;
    assign pop_cmd   = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_QW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/blkfp_back.sv =====
module blkfp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_avail,
    output logic                   q_pop,
    input  blkfp_pkg::cmd_t        q_cmd,
    output logic                   m_valid,
    input  logic                   m_ready,
    output blkfp_pkg::out_item_t   m_item
);
    import blkfp_pkg::*;

    logic [HASH_W-1:0] table_mem [MAX_BLOCKS];
    logic [HASH_W-1:0] rd_data_reg;
    logic [HASH_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    cmd_t              s1_cmd_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic [MARK_W-1:0] marked_reg, marked_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [HASH_W-1:0] stored;
    logic              need_out;
    logic              out_free;
    logic              s1_done;
    logic              changed;
    logic [CNT_W-1:0]  cnt_out;
    logic [MARK_W-1:0] marked_sum;
    logic              wr_en;

    assign stored     = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign need_out   = (s1_cmd_reg.kind != CMD_WRITE);
    assign out_free   = !out_valid_reg || m_ready;
    assign s1_done    = s1_valid_reg && (!need_out || out_free);
    assign q_pop      = q_avail && (!s1_valid_reg || s1_done);

    assign changed    = (s1_cmd_reg.kind == CMD_BLOCK) && !s1_cmd_reg.too_big
                     && (stored != s1_cmd_reg.data);
    assign cnt_out    = changed ? s1_cmd_reg.cnt : '0;
    assign marked_sum = marked_reg + MARK_W'(cnt_out);
    assign wr_en      = s1_done && ((s1_cmd_reg.kind == CMD_WRITE) || changed);

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        marked_next    = marked_reg;
        s1_valid_next  = s1_valid_reg;
        if (s1_done) begin
            s1_valid_next = 1'b0;
        end
        if (q_pop) begin
            s1_valid_next = 1'b1;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s1_done) begin
            case (s1_cmd_reg.kind)
                CMD_READ: begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.kind         = KIND_READ;
                    out_next.stored_value = stored;
                end
                CMD_BLOCK: begin
                    out_valid_next        = 1'b1;
                    out_next.kind         = KIND_BLOCK;
                    out_next.block_index  = s1_cmd_reg.addr;
                    out_next.block_hash   = s1_cmd_reg.data;
                    out_next.changed      = changed;
                    out_next.first_chunk  = s1_cmd_reg.first_chunk;
                    out_next.chunk_count  = cnt_out;
                    out_next.marked_total = marked_sum;
                    out_next.final_res    = s1_cmd_reg.last;
                    out_next.status       = s1_cmd_reg.too_big;
                    out_next.stored_value = '0;
                    marked_next           = s1_cmd_reg.last ? '0 : marked_sum;
                end
                default: begin
                    out_next = out_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            marked_reg    <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            marked_reg    <= marked_next;
            // a write in the same cycle as the read is not seen by the memory
            if (q_pop) begin
                fwd_hit_reg <= wr_en && (s1_cmd_reg.addr == q_cmd.addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (q_pop) begin
            s1_cmd_reg   <= q_cmd;
            rd_data_reg  <= table_mem[q_cmd.addr];
            fwd_data_reg <= s1_cmd_reg.data;
        end
        if (wr_en) begin
            table_mem[s1_cmd_reg.addr] <= s1_cmd_reg.data;
        end
    end

endmodule

// ===== design/block_fingerprint_change_detector_unit.sv =====
// Items pass the queue, the back stage and the output register. Throughput: one item
// per cycle unless the output stalls; the per-byte hash multiply and the dual-port
// fingerprint table (one read and one write a cycle) set that figure. Byte items that
// do not end a block cause no result. Reset: synchronous, active low; clears the queue,
// the pipeline, byte position and marked count; the hash returns to the FNV basis,
// card_size to 1, table_entries to 1024. The fingerprint table is not cleared.
module block_fingerprint_change_detector_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  blkfp_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output blkfp_pkg::out_item_t                m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [blkfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blkfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import blkfp_pkg::*;

    logic push_valid;
    cmd_t push_cmd;
    logic q_full;
    logic q_avail;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    blkfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    blkfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop_avail  (q_avail),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    blkfp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_avail (q_avail),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ===== dv/blkfp_checker.sv =====
module blkfp_checker
    import blkfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [HASH_W-1:0] fp_table [MAX_BLOCKS];
    logic [HASH_W-1:0] run_hash;
    logic [31:0]       byte_pos;
    logic [MARK_W-1:0] marked;
    logic [POS_W-1:0]  card_size;
    logic [TE_W-1:0]   table_entries;
    out_item_t         block_results [$];
    out_item_t         oldest;
    int                mismatches = 0;
    int                due_count = 0;

    assign fail_count  = mismatches;
    assign results_due = due_count;

    task automatic hash_and_compare(input in_item_t it);
        out_item_t   r;
        logic [31:0] size, blk, first, nblocks, nchunks, eff, cnt;
        logic        last, too_big;
        r = '0;
        if (it.op == OP_WRITE) begin
            fp_table[it.entry_index] = it.entry_value;
        end else if (it.op == OP_READ) begin
            r.kind = KIND_READ;
            r.stored_value = fp_table[it.entry_index];
            block_results.push_back(r);
        end else if (it.op == OP_BYTE) begin
            run_hash = (run_hash ^ {24'd0, it.card_byte}) * FNV_PRIME;
            byte_pos = byte_pos + 1;
            size = (card_size == '0) ? 32'd1 : 32'(card_size);
            // a lowered card size ends the scan on the next byte
            last = byte_pos >= size;
            if (last || byte_pos % BLOCK_BYTES == 0) begin
                blk     = (byte_pos - 1) / BLOCK_BYTES;
                first   = blk * BLOCK_BYTES / CHUNK_BYTES;
                nblocks = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
                nchunks = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
                eff     = 32'(table_entries);
                if (eff > MAX_BLOCKS) begin
                    eff = MAX_BLOCKS;
                end
                too_big = (nblocks > eff) || (blk >= eff);
                cnt = 0;
                if (!too_big && fp_table[blk[ADDR_W-1:0]] != run_hash) begin
                    fp_table[blk[ADDR_W-1:0]] = run_hash;
                    r.changed = 1'b1;
                    if (first < nchunks) begin
                        cnt = (nchunks - first > CHUNKS_IN_BLOCK) ? CHUNKS_IN_BLOCK
                                                                  : nchunks - first;
                    end
                    marked = marked + MARK_W'(cnt);
                end
                r.kind         = KIND_BLOCK;
                r.block_index  = blk[ADDR_W-1:0];
                r.block_hash   = run_hash;
                r.first_chunk  = first[FIRST_W-1:0];
                r.chunk_count  = cnt[CNT_W-1:0];
                r.marked_total = marked;
                r.final_res    = last;
                r.status       = too_big;
                block_results.push_back(r);
                run_hash = FNV_BASIS;
                if (last) begin
                    byte_pos = 0;
                    marked = '0;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            block_results.delete();
            run_hash = FNV_BASIS;
            byte_pos = 0;
            marked = '0;
            card_size = POS_W'(1);
            table_entries = TE_W'(MAX_BLOCKS);
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CARD_SIZE) begin
                    card_size = cfg_data[POS_W-1:0];
                end else if (cfg_index == CFG_TABLE_ENTRIES) begin
                    table_entries = cfg_data[TE_W-1:0];
                end
            end
            if (s_valid && s_ready) begin
                hash_and_compare(s_item);
            end
            if (m_valid && m_ready) begin
                if (block_results.size() == 0) begin
                    $display("%0t ns: result with none expected, got 0x%0h", $time, m_item);
                    mismatches++;
                end else begin
                    oldest = block_results.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(m_item.kind));
                    check_field("block_index", 32'(oldest.block_index),
                                32'(m_item.block_index));
                    check_field("block_hash", oldest.block_hash, m_item.block_hash);
                    check_field("changed", 32'(oldest.changed), 32'(m_item.changed));
                    check_field("first_chunk", 32'(oldest.first_chunk),
                                32'(m_item.first_chunk));
                    check_field("chunk_count", 32'(oldest.chunk_count),
                                32'(m_item.chunk_count));
                    check_field("marked_total", 32'(oldest.marked_total),
                                32'(m_item.marked_total));
                    check_field("final_res", 32'(oldest.final_res), 32'(m_item.final_res));
                    check_field("status", 32'(oldest.status), 32'(m_item.status));
                    check_field("stored_value", oldest.stored_value, m_item.stored_value);
                end
            end
        end
        due_count = block_results.size();
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import blkfp_pkg::*;

    localparam logic [1:0]           OP_NONE       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = 8'hFF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_CARD      = 4194304;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    results_due;
    int                    cycle_count = 0;
    bit                    no_idle = 1'b0;
    bit                    hold_req = 1'b0;
    bit                    written [MAX_BLOCKS];
    int                    written_q [$];

    always #1 aclk = ~aclk;

    block_fingerprint_change_detector_unit u_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_item,
        .m_valid, .m_ready, .m_item,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    blkfp_checker u_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_item,
        .m_valid, .m_ready, .m_item,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .results_due
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic in_item_t random_item(input logic [1:0] op);
        in_item_t it;
        it.op          = op;
        it.entry_index = ADDR_W'($urandom);
        it.entry_value = $urandom;
        it.card_byte   = 8'($urandom);
        return it;
    endfunction

    // narrow alphabet half the time so rescans can match the stored fingerprint
    function automatic logic [7:0] random_byte();
        if ($urandom_range(1, 0) == 0) begin
            return ($urandom_range(1, 0) == 0) ? 8'h00 : 8'hFF;
        end
        return 8'($urandom);
    endfunction

    function automatic int any_written();
        return written_q[$urandom_range(written_q.size() - 1, 0)];
    endfunction

    function automatic int pick_card_size();
        case ($urandom_range(9, 0))
            0:       return 0;
            1:       return $urandom_range(700, 25);
            2, 3:    return 1;
            default: return $urandom_range(24, 1);
        endcase
    endfunction

    function automatic int pick_entries();
        case ($urandom_range(7, 0))
            0:       return 0;
            1:       return 2047;
            2:       return $urandom_range(2047, 1);
            default: return MAX_BLOCKS;
        endcase
    endfunction

    // valid stays up across back-to-back items
    task automatic offer(input in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(16, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic store_fingerprint(input int idx, input logic [HASH_W-1:0] value);
        in_item_t it;
        it = random_item(OP_WRITE);
        it.entry_index = ADDR_W'(idx);
        it.entry_value = value;
        if (!written[idx]) begin
            written[idx] = 1'b1;
            written_q.push_back(idx);
        end
        offer(it);
    endtask

    task automatic fetch_fingerprint(input int idx);
        in_item_t it;
        it = random_item(OP_READ);
        it.entry_index = ADDR_W'(idx);
        offer(it);
    endtask

    task automatic push_byte(input logic [7:0] b);
        in_item_t it;
        it = random_item(OP_BYTE);
        it.card_byte = b;
        offer(it);
    endtask

    task automatic stream_bytes(input int n);
        repeat (n) push_byte(random_byte());
    endtask

    // writes and bytes that end no block leave no result, so give the pipe time to empty
    task automatic settle();
        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reconfigure(input int size, input int entries);
        logic [CFG_DATA_W-1:0] data;
        settle();
        data = $urandom;
        data[POS_W-1:0] = POS_W'(size);
        write_reg(CFG_CARD_SIZE, data);
        data = $urandom;
        data[TE_W-1:0] = TE_W'(entries);
        write_reg(CFG_TABLE_ENTRIES, data);
    endtask

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = no_idle ? 0 : $urandom_range(16, 0);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int n;
        int roll;
        int random_items;
        random_items = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        store_fingerprint(0, '0);
        store_fingerprint(MAX_BLOCKS - 1, '1);
        store_fingerprint(1, $urandom);
        fetch_fingerprint(MAX_BLOCKS - 1);
        fetch_fingerprint(0);
        // one-byte card after reset; the repeat must come back unchanged
        push_byte(8'hFF);
        push_byte(8'hFF);
        offer(random_item(OP_NONE));
        settle();
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_TOP_INDEX, $urandom);
        // zero size acts as one byte, zero entries flags every block
        reconfigure(0, 0);
        push_byte(8'h00);
        // entry count above the table depth is clipped
        reconfigure(3, 2047);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        // lower the size mid-scan: the next byte closes the scan
        push_byte(8'h01);
        push_byte(8'hFE);
        reconfigure(1, MAX_BLOCKS);
        push_byte(8'h55);
        fetch_fingerprint(0);

        // two blocks: first one full and capped at a block of chunks, second one short
        no_idle = 1'b1;
        reconfigure(BLOCK_BYTES + 700, MAX_BLOCKS);
        stream_bytes(BLOCK_BYTES + 700);
        no_idle = 1'b0;
        // largest card, one full block, then block 1 falls beyond a one-entry table
        reconfigure(MAX_CARD, MAX_BLOCKS);
        stream_bytes(BLOCK_BYTES);
        reconfigure(1, 1);
        stream_bytes(1);
        reconfigure(1, MAX_BLOCKS);

        // receiver stalls while reads pile up behind it
        hold_req = 1'b1;
        repeat (24) fetch_fingerprint(any_written());

        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(3, 0) == 0) begin
                reconfigure(pick_card_size(), pick_entries());
            end
            no_idle = ($urandom_range(5, 0) == 0);
            n = $urandom_range(40, 4);
            repeat (n) begin
                roll = $urandom_range(99, 0);
                if (roll < 72) begin
                    push_byte(random_byte());
                end else if (roll < 84) begin
                    fetch_fingerprint(any_written());
                end else if (roll < 95) begin
                    store_fingerprint((roll < 90) ? 0 : $urandom_range(MAX_BLOCKS - 1, 0),
                                      $urandom);
                end else begin
                    offer(random_item(OP_NONE));
                    random_items--;
                end
                random_items++;
            end
        end

        no_idle = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/blkfp_pkg.sv
design/blkfp_front.sv
design/blkfp_queue.sv
design/blkfp_back.sv
design/block_fingerprint_change_detector_unit.sv
dv/blkfp_checker.sv
dv/tb_top.sv
